// ===== src/noise_lfsr_channel_top_defines.svh =====
// Assertion macros for the noise LFSR channel.
// Used by the controller and datapath. Expects aclk and aresetn in scope.
`ifndef NOISE_LFSR_CHANNEL_TOP_DEFINES_SVH
`define NOISE_LFSR_CHANNEL_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define NLC_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define NLC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/nlc_pkg.sv =====
// Shared types, constants and the period tables of the noise LFSR channel.
// No dependencies.
`timescale 1ns / 1ps

package nlc_pkg;

    // Field widths
    localparam int STEP_W     = 24;
    localparam int VOL_W      = 4;
    localparam int SAMPLE_W   = 5;
    localparam int PERIOD_W   = 12;
    localparam int LFSR_W     = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int QUOT_W     = 4;
    localparam int DIV_CNT_W  = 2;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 15'h4000;
    localparam int TAP_LONG  = 1;
    localparam int TAP_SHORT = 6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_INDEX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_TAP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REGION       = 2'd2;

    // Period tables, in timer units before the fraction shift
    localparam logic [PERIOD_W-1:0] PERIOD_TABLE_A [16] = '{
        12'h004, 12'h008, 12'h010, 12'h020, 12'h040, 12'h060, 12'h080, 12'h0A0,
        12'h0CA, 12'h0FE, 12'h17C, 12'h1FC, 12'h2FA, 12'h3F8, 12'h7F2, 12'hFE4
    };
    localparam logic [PERIOD_W-1:0] PERIOD_TABLE_B [16] = '{
        12'h004, 12'h007, 12'h00E, 12'h01E, 12'h03C, 12'h058, 12'h076, 12'h094,
        12'h0BC, 12'h0EC, 12'h162, 12'h1D8, 12'h2C4, 12'h3B0, 12'h762, 12'hEC2
    };

    function automatic logic [PERIOD_W-1:0] period_lookup(input logic       region,
                                                          input logic [3:0] idx);
        return region ? PERIOD_TABLE_B[idx] : PERIOD_TABLE_A[idx];
    endfunction

    // Source of the delivered sample
    typedef enum logic [1:0] {
        RES_ZERO,
        RES_HELD,
        RES_QUOT
    } res_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic     load;
        logic     shift;
        logic     div_init;
        logic     div_step;
        logic     out_load;
        res_sel_t res_sel;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic enabled;
        logic timer_neg;
        logic count_zero;
        logic out_free;
    } dp_status_t;

endpackage

// ===== src/nlc_ctrl.sv =====
// Controller of the noise LFSR channel: sequences load, shifts, division, output.
// Depends on nlc_pkg and noise_lfsr_channel_top_defines.svh.
`timescale 1ns / 1ps
`include "noise_lfsr_channel_top_defines.svh"

module nlc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  nlc_pkg::dp_status_t sts_i,
    output nlc_pkg::ctrl_cmd_t  cmd_o
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DIV,
        ST_OUT
    } state_t;

    localparam logic [nlc_pkg::DIV_CNT_W-1:0] DIV_LAST =
        nlc_pkg::DIV_CNT_W'(nlc_pkg::QUOT_W - 1);

    state_t                            state_reg, state_next;
    logic [nlc_pkg::DIV_CNT_W-1:0]     div_cnt_reg, div_cnt_next;
    nlc_pkg::res_sel_t                 res_sel_reg, res_sel_next;

    // Next state and commands
    always_comb begin
        state_next    = state_reg;
        div_cnt_next  = div_cnt_reg;
        res_sel_next  = res_sel_reg;
        s_ready       = 1'b0;
        cmd_o         = '0;
        cmd_o.res_sel = res_sel_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_o.load = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!sts_i.enabled) begin
                    res_sel_next = nlc_pkg::RES_ZERO;
                    state_next   = ST_OUT;
                end else if (sts_i.timer_neg) begin
                    cmd_o.shift = 1'b1;
                end else if (sts_i.count_zero) begin
                    res_sel_next = nlc_pkg::RES_HELD;
                    state_next   = ST_OUT;
                end else begin
                    cmd_o.div_init = 1'b1;
                    div_cnt_next   = '0;
                    state_next     = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd_o.div_step = 1'b1;
                div_cnt_next   = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST) begin
                    res_sel_next = nlc_pkg::RES_QUOT;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                if (sts_i.out_free) begin
                    cmd_o.out_load = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    // State and registered control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
            res_sel_reg <= nlc_pkg::RES_ZERO;
        end else begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
            res_sel_reg <= res_sel_next;
        end
    end

    `NLC_ASSERT_IMPL(a_shift_only_when_due, cmd_o.shift, sts_i.timer_neg && sts_i.enabled, "shift without negative timer")
    `NLC_ASSERT_IMPL(a_out_only_when_free, cmd_o.out_load, sts_i.out_free, "output overwritten")
    `NLC_ASSERT_IMPL(a_div_nonzero_count, cmd_o.div_init, !sts_i.count_zero, "division by zero count")
    `NLC_ASSERT_NEXT(a_load_then_run, cmd_o.load, state_reg == ST_RUN && !s_ready, "load not followed by run")

endmodule

// ===== src/nlc_datapath.sv =====
// Datapath of the noise LFSR channel: config, timer, LFSR, sum, divider, output register.
// Depends on nlc_pkg and noise_lfsr_channel_top_defines.svh.
`timescale 1ns / 1ps
`include "noise_lfsr_channel_top_defines.svh"

module nlc_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration
    input  logic                                 cfg_valid,
    input  logic [nlc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [nlc_pkg::CFG_DATA_W-1:0]       cfg_data,
    // input payload
    input  logic [nlc_pkg::STEP_W-1:0]           s_time_step,
    input  logic                                 s_channel_enabled,
    input  logic [nlc_pkg::VOL_W-1:0]            s_volume,
    // output channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [nlc_pkg::SAMPLE_W-1:0]  m_sample,
    // control
    input  nlc_pkg::ctrl_cmd_t                   cmd_i,
    output nlc_pkg::dp_status_t                  sts_o
);

    // Timer holds [-2^STEP_W, period << FRAC_BITS) without wrapping
    localparam int PER_SH_W = nlc_pkg::PERIOD_W + FRAC_BITS;
    localparam int TIMER_W  = ((PER_SH_W > nlc_pkg::STEP_W) ? PER_SH_W : nlc_pkg::STEP_W) + 1;
    // Shifts per item are at most 2^(STEP_W - 2 - FRAC_BITS) (smallest period is 4)
    localparam int CNT_LOG  = (FRAC_BITS < nlc_pkg::STEP_W - 2) ?
                              (nlc_pkg::STEP_W - 2 - FRAC_BITS) : 0;
    localparam int CNT_W    = CNT_LOG + 1;
    localparam int REM_W    = CNT_W + nlc_pkg::VOL_W;
    localparam int SUM_W    = REM_W + 1;
    localparam int DVS_W    = CNT_W + nlc_pkg::QUOT_W - 1;

    // Configuration registers
    logic [3:0] period_idx_reg;
    logic       short_tap_reg;
    logic       region_reg;

    // Architectural state
    logic signed [TIMER_W-1:0]            timer_reg;
    logic [nlc_pkg::LFSR_W-1:0]           lfsr_reg;
    logic signed [nlc_pkg::SAMPLE_W-1:0]  held_reg;

    // Per-transaction working registers
    logic                                 enabled_reg;
    logic [nlc_pkg::VOL_W-1:0]            vol_reg;
    logic signed [SUM_W-1:0]              sum_reg;
    logic [CNT_W-1:0]                     count_reg;
    logic [REM_W-1:0]                     rem_reg;
    logic [DVS_W-1:0]                     dvs_reg;
    logic [nlc_pkg::QUOT_W-1:0]           quot_reg;
    logic                                 neg_reg;
    logic signed [nlc_pkg::SAMPLE_W-1:0]  sample_reg;
    logic                                 valid_reg;

    logic [nlc_pkg::PERIOD_W-1:0]         period;
    logic signed [TIMER_W-1:0]            period_ext;
    logic signed [TIMER_W-1:0]            step_ext;
    logic                                 tap_bit;
    logic                                 positive;
    logic [nlc_pkg::LFSR_W-1:0]           lfsr_next;
    logic signed [nlc_pkg::SAMPLE_W-1:0]  vol_s;
    logic signed [nlc_pkg::SAMPLE_W-1:0]  shift_val;
    logic signed [SUM_W-1:0]              sum_abs;
    logic [REM_W-1:0]                     dvs_ext;
    logic                                 div_ge;
    logic signed [nlc_pkg::SAMPLE_W-1:0]  quot_s;
    logic signed [nlc_pkg::SAMPLE_W-1:0]  result;
    logic                                 out_free;

    // Period and step in timer units
    assign period     = nlc_pkg::period_lookup(region_reg, period_idx_reg);
    assign period_ext = $signed(TIMER_W'({period, {FRAC_BITS{1'b0}}}));
    assign step_ext   = $signed(TIMER_W'(s_time_step));

    // LFSR step and its signed contribution
    assign tap_bit   = short_tap_reg ? lfsr_reg[nlc_pkg::TAP_SHORT] : lfsr_reg[nlc_pkg::TAP_LONG];
    assign positive  = ~lfsr_reg[0];
    assign lfsr_next = {lfsr_reg[0] ^ tap_bit, lfsr_reg[nlc_pkg::LFSR_W-1:1]};
    assign vol_s     = $signed({1'b0, vol_reg});
    assign shift_val = positive ? vol_s : -vol_s;

    // Divider: magnitude of the sum, one quotient bit per cycle
    assign sum_abs = sum_reg[SUM_W-1] ? -sum_reg : sum_reg;
    assign dvs_ext = REM_W'(dvs_reg);
    assign div_ge  = (rem_reg >= dvs_ext);
    assign quot_s  = $signed({1'b0, quot_reg});

    // Result select
    always_comb begin
        unique case (cmd_i.res_sel)
            nlc_pkg::RES_ZERO: result = '0;
            nlc_pkg::RES_HELD: result = held_reg;
            nlc_pkg::RES_QUOT: result = neg_reg ? -quot_s : quot_s;
            default:           result = '0;
        endcase
    end

    assign out_free = !valid_reg || m_ready;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_idx_reg <= '0;
            short_tap_reg  <= 1'b0;
            region_reg     <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                nlc_pkg::REG_PERIOD_INDEX: period_idx_reg <= cfg_data;
                nlc_pkg::REG_SHORT_TAP:    short_tap_reg  <= cfg_data[0];
                nlc_pkg::REG_REGION:       region_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Timer, LFSR and held sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_reg <= '0;
            lfsr_reg  <= nlc_pkg::LFSR_SEED;
            held_reg  <= '0;
        end else if (cmd_i.load) begin
            if (s_channel_enabled) begin
                timer_reg <= timer_reg - step_ext;
            end
        end else if (cmd_i.shift) begin
            timer_reg <= timer_reg + period_ext;
            lfsr_reg  <= lfsr_next;
            held_reg  <= shift_val;
        end
    end

    // Accumulation and division
    always_ff @(posedge aclk) begin
        if (cmd_i.load) begin
            enabled_reg <= s_channel_enabled;
            vol_reg     <= s_volume;
            sum_reg     <= '0;
            count_reg   <= '0;
        end else if (cmd_i.shift) begin
            sum_reg   <= sum_reg + SUM_W'(shift_val);
            count_reg <= count_reg + 1'b1;
        end
        if (cmd_i.div_init) begin
            rem_reg  <= sum_abs[REM_W-1:0];
            dvs_reg  <= {count_reg, {(nlc_pkg::QUOT_W-1){1'b0}}};
            quot_reg <= '0;
            neg_reg  <= sum_reg[SUM_W-1];
        end else if (cmd_i.div_step) begin
            rem_reg  <= div_ge ? (rem_reg - dvs_ext) : rem_reg;
            dvs_reg  <= dvs_reg >> 1;
            quot_reg <= {quot_reg[nlc_pkg::QUOT_W-2:0], div_ge};
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd_i.out_load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.out_load) begin
            sample_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_sample = sample_reg;

    assign sts_o.enabled    = enabled_reg;
    assign sts_o.timer_neg  = timer_reg[TIMER_W-1];
    assign sts_o.count_zero = (count_reg == '0);
    assign sts_o.out_free   = out_free;

    `NLC_ASSERT_IMPL(a_lfsr_nonzero, 1'b1, lfsr_reg != '0, "LFSR reached all zeros")
    `NLC_ASSERT_IMPL(a_held_in_range, 1'b1, held_reg >= -5'sd15, "held sample out of range")
    `NLC_ASSERT_NEXT(a_shift_counted, cmd_i.shift, count_reg != '0, "shift count wrapped")

endmodule

// ===== src/noise_lfsr_channel_top.sv =====
// Noise LFSR channel: per request, runs the phase timer, LFSR shifts and averaging.
// Disabled channel or no shift: zero or held sample goes from RUN to OUT and is registered there;
// with N shifts (one per cycle), the sum is divided by N in DIV first (N <= 2^(22-FRAC_BITS), 64 at 16).
// Requests: one in flight, next accepted once the sample is loaded into the output register; m_ready stalls hold OUT.
// Reset (aresetn, synchronous, low): timer 0, LFSR 0x4000, held sample 0, config 0.
// Depends on nlc_pkg, nlc_ctrl and nlc_datapath.
`timescale 1ns / 1ps

module noise_lfsr_channel_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nlc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [nlc_pkg::CFG_DATA_W-1:0]      cfg_data,
    // request channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [nlc_pkg::STEP_W-1:0]          s_time_step,
    input  logic                                s_channel_enabled,
    input  logic [nlc_pkg::VOL_W-1:0]           s_volume,
    // sample channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [nlc_pkg::SAMPLE_W-1:0] m_sample
);

    nlc_pkg::ctrl_cmd_t  cmd;
    nlc_pkg::dp_status_t sts;

    // Config writes must only happen while idle; the block does not enforce this, and writes are always taken
    assign cfg_ready = 1'b1;

    nlc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts_i   (sts),
        .cmd_o   (cmd)
    );

    nlc_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_time_step       (s_time_step),
        .s_channel_enabled (s_channel_enabled),
        .s_volume          (s_volume),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_sample          (m_sample),
        .cmd_i             (cmd),
        .sts_o             (sts)
    );

endmodule
